### rtl/iamc_pkg.sv
// Types, constants and helper functions shared by the intrusion alarm mode controller.
package iamc_pkg;

    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned HOUR_W      = 5;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned S_TDATA_W   = 24;
    localparam int unsigned S_TUSER_W   = 2;
    localparam int unsigned M_TDATA_W   = 16;

    localparam logic [COUNT_W-1:0] MAX_SENSORS = 4'd15;

    typedef enum logic [2:0] {
        MODE_SLAVE    = 3'd0,
        MODE_EASY     = 3'd1,
        MODE_PREGUARD = 3'd2,
        MODE_GUARD    = 3'd3,
        MODE_SILENT   = 3'd4,
        MODE_PREALARM = 3'd5,
        MODE_ALARM    = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_MOTION = 2'd1,
        OP_CMD    = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EASY_TIMEOUT     = 3'd0,
        CFG_GUARD_TIMEOUT    = 3'd1,
        CFG_SILENT_TIMEOUT   = 3'd2,
        CFG_PREALARM_TIMEOUT = 3'd3,
        CFG_ALARM_TIMEOUT    = 3'd4,
        CFG_SILENT_START     = 3'd5,
        CFG_SILENT_END       = 3'd6
    } cfg_idx_t;

    localparam logic [CFG_DATA_W-1:0] RST_EASY_TIMEOUT     = 16'd600;
    localparam logic [CFG_DATA_W-1:0] RST_GUARD_TIMEOUT    = 16'd3600;
    localparam logic [CFG_DATA_W-1:0] RST_SILENT_TIMEOUT   = 16'd1800;
    localparam logic [CFG_DATA_W-1:0] RST_PREALARM_TIMEOUT = 16'd30;
    localparam logic [CFG_DATA_W-1:0] RST_ALARM_TIMEOUT    = 16'd300;
    localparam logic [HOUR_W-1:0]     RST_SILENT_START     = 5'd21;
    localparam logic [HOUR_W-1:0]     RST_SILENT_END       = 5'd9;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] easy_timeout;
        logic [CFG_DATA_W-1:0] guard_timeout;
        logic [CFG_DATA_W-1:0] silent_timeout;
        logic [CFG_DATA_W-1:0] prealarm_timeout;
        logic [CFG_DATA_W-1:0] alarm_timeout;
        logic [HOUR_W-1:0]     silent_start_hour;
        logic [HOUR_W-1:0]     silent_end_hour;
    } cfg_t;

    // packed lowest field last so that target_mode sits in bit 0 upwards
    typedef struct packed {
        logic [COUNT_W-1:0] motion_outer;
        logic [COUNT_W-1:0] motion_bed;
        logic [COUNT_W-1:0] motion_total;
        logic [HOUR_W-1:0]  hour_now;
        logic [2:0]         target_mode;
    } item_t;

    typedef struct packed {
        logic       wall_warning;
        logic       timer_running;
        logic       mode_entered;
        logic [2:0] mode_before;
        logic [2:0] mode_now;
    } result_t;

    function automatic logic [CFG_DATA_W-1:0] mode_timeout(mode_t m, cfg_t c);
        logic [CFG_DATA_W-1:0] t;
        unique case (m)
            MODE_EASY:     t = c.easy_timeout;
            MODE_PREGUARD: t = c.prealarm_timeout;
            MODE_GUARD:    t = c.guard_timeout;
            MODE_SILENT:   t = c.silent_timeout;
            MODE_PREALARM: t = c.prealarm_timeout;
            MODE_ALARM:    t = c.alarm_timeout;
            default:       t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_count(logic [COUNT_W-1:0] v);
        return (v > MAX_SENSORS) ? MAX_SENSORS : v;
    endfunction

endpackage

### rtl/iamc_cfg_regs.sv
// Configuration register file: timeouts and silent-hours window.
module iamc_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 wr_en,
    input  logic [iamc_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [iamc_pkg::CFG_DATA_W-1:0]      wr_data,
    output iamc_pkg::cfg_t                       cfg
);

    iamc_pkg::cfg_t cfg_reg;
    iamc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (iamc_pkg::cfg_idx_t'(wr_index))
                iamc_pkg::CFG_EASY_TIMEOUT:     cfg_next.easy_timeout     = wr_data;
                iamc_pkg::CFG_GUARD_TIMEOUT:    cfg_next.guard_timeout    = wr_data;
                iamc_pkg::CFG_SILENT_TIMEOUT:   cfg_next.silent_timeout   = wr_data;
                iamc_pkg::CFG_PREALARM_TIMEOUT: cfg_next.prealarm_timeout = wr_data;
                iamc_pkg::CFG_ALARM_TIMEOUT:    cfg_next.alarm_timeout    = wr_data;
                iamc_pkg::CFG_SILENT_START:
                    cfg_next.silent_start_hour = wr_data[iamc_pkg::HOUR_W-1:0];
                iamc_pkg::CFG_SILENT_END:
                    cfg_next.silent_end_hour   = wr_data[iamc_pkg::HOUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.easy_timeout      <= iamc_pkg::RST_EASY_TIMEOUT;
            cfg_reg.guard_timeout     <= iamc_pkg::RST_GUARD_TIMEOUT;
            cfg_reg.silent_timeout    <= iamc_pkg::RST_SILENT_TIMEOUT;
            cfg_reg.prealarm_timeout  <= iamc_pkg::RST_PREALARM_TIMEOUT;
            cfg_reg.alarm_timeout     <= iamc_pkg::RST_ALARM_TIMEOUT;
            cfg_reg.silent_start_hour <= iamc_pkg::RST_SILENT_START;
            cfg_reg.silent_end_hour   <= iamc_pkg::RST_SILENT_END;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/iamc_step.sv
// Next-state and result logic for one word: tick, motion report or forced mode.
module iamc_step #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  iamc_pkg::cfg_t           cfg,
    input  logic [1:0]               opcode,
    input  iamc_pkg::item_t          item,
    input  iamc_pkg::mode_t          mode,
    input  logic [TIMER_WIDTH-1:0]   count,
    input  logic                     armed,
    output iamc_pkg::mode_t          mode_next,
    output logic [TIMER_WIDTH-1:0]   count_next,
    output logic                     armed_next,
    output iamc_pkg::result_t        result
);

    logic [iamc_pkg::COUNT_W-1:0]    total;
    logic [iamc_pkg::COUNT_W-1:0]    bed;
    logic [iamc_pkg::COUNT_W-1:0]    outer;
    logic                            inner_any;
    logic                            silent;
    logic [TIMER_WIDTH-1:0]          count_dec;
    logic                            do_arm;
    logic [iamc_pkg::CFG_DATA_W-1:0] arm_val;
    logic [TIMER_WIDTH-1:0]          arm_t;
    logic                            do_enter;
    logic [2:0]                      enter_raw;
    logic [TIMER_WIDTH-1:0]          enter_t;
    logic                            warn;
    iamc_pkg::mode_t                 mode_n;
    logic [TIMER_WIDTH-1:0]          count_n;
    logic                            armed_n;

    always_comb begin
        total     = iamc_pkg::sat_count(item.motion_total);
        bed       = iamc_pkg::sat_count(item.motion_bed);
        outer     = iamc_pkg::sat_count(item.motion_outer);
        inner_any = total > outer;
        silent    = (item.hour_now < cfg.silent_end_hour) ||
                    (item.hour_now > cfg.silent_start_hour);
        count_dec = (count != '0) ? count - TIMER_WIDTH'(1) : count;

        do_arm    = 1'b0;
        arm_val   = '0;
        do_enter  = 1'b0;
        enter_raw = mode;
        warn      = 1'b0;
        mode_n    = mode;
        count_n   = count;
        armed_n   = armed;

        unique case (iamc_pkg::op_t'(opcode))
            iamc_pkg::OP_TICK: begin
                if (armed) begin
                    count_n = count_dec;
                    if (count_dec == '0) begin
                        armed_n = 1'b0;
                        unique case (mode)
                            iamc_pkg::MODE_EASY: begin
                                if (!silent) begin
                                    do_arm  = 1'b1;
                                    arm_val = cfg.easy_timeout;
                                end else begin
                                    do_enter  = 1'b1;
                                    enter_raw = iamc_pkg::MODE_SILENT;
                                end
                            end
                            iamc_pkg::MODE_PREGUARD, iamc_pkg::MODE_ALARM: begin
                                do_enter  = 1'b1;
                                enter_raw = inner_any ? iamc_pkg::MODE_PREALARM
                                                      : iamc_pkg::MODE_GUARD;
                            end
                            iamc_pkg::MODE_GUARD: begin
                                do_arm  = 1'b1;
                                arm_val = cfg.guard_timeout;
                            end
                            iamc_pkg::MODE_SILENT: begin
                                if (!silent) begin
                                    do_enter  = 1'b1;
                                    enter_raw = iamc_pkg::MODE_GUARD;
                                end else begin
                                    do_arm  = 1'b1;
                                    arm_val = cfg.silent_timeout;
                                end
                            end
                            iamc_pkg::MODE_PREALARM: begin
                                do_enter  = 1'b1;
                                enter_raw = iamc_pkg::MODE_ALARM;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            iamc_pkg::OP_MOTION: begin
                unique case (mode)
                    iamc_pkg::MODE_EASY: begin
                        do_arm  = inner_any;
                        arm_val = cfg.easy_timeout;
                        warn    = outer != '0;
                    end
                    iamc_pkg::MODE_PREGUARD, iamc_pkg::MODE_ALARM: begin
                        do_enter  = 1'b1;
                        enter_raw = inner_any ? iamc_pkg::MODE_PREALARM
                                              : iamc_pkg::MODE_GUARD;
                    end
                    iamc_pkg::MODE_GUARD: begin
                        do_enter  = inner_any;
                        enter_raw = iamc_pkg::MODE_PREALARM;
                        warn      = outer != '0;
                    end
                    iamc_pkg::MODE_SILENT: begin
                        if (bed != '0) begin
                            do_enter  = 1'b1;
                            enter_raw = iamc_pkg::MODE_EASY;
                        end else if (inner_any) begin
                            do_enter  = 1'b1;
                            enter_raw = iamc_pkg::MODE_PREALARM;
                        end
                    end
                    iamc_pkg::MODE_PREALARM: begin
                        warn = outer != '0;
                    end
                    default: ;
                endcase
            end
            iamc_pkg::OP_CMD: begin
                do_enter  = 1'b1;
                enter_raw = item.target_mode;
            end
            default: ;
        endcase

        arm_t = TIMER_WIDTH'(arm_val);
        if (do_arm && arm_t != '0) begin
            count_n = arm_t;
            armed_n = 1'b1;
        end

        enter_t = TIMER_WIDTH'(iamc_pkg::mode_timeout(iamc_pkg::mode_t'(enter_raw), cfg));
        if (do_enter && enter_raw <= iamc_pkg::MODE_ALARM && enter_raw != mode) begin
            mode_n = iamc_pkg::mode_t'(enter_raw);
            if (enter_t != '0) begin
                count_n = enter_t;
                armed_n = 1'b1;
            end
        end
    end

    assign mode_next  = mode_n;
    assign count_next = count_n;
    assign armed_next = armed_n;

    assign result.mode_now      = mode_n;
    assign result.mode_before   = mode;
    assign result.mode_entered  = mode_n != mode;
    assign result.timer_running = armed_n;
    assign result.wall_warning  = warn;

endmodule

### rtl/intrusion_alarm_mode_controller.sv
// Intrusion alarm mode controller: input register, mode state and result register.
//
// Input words arrive on the s_ channel: s_tuser carries the opcode (tick, motion
// report, forced mode command) and s_tdata the target mode, hour and motion counts.
// Each accepted word yields exactly one result word on the m_ channel with the
// mode after and before the word, a mode-change flag, the timer-armed flag and
// the outer-wall warning.
// An accepted word is held in the input register, evaluated against the mode and
// countdown state, and its result is loaded into the output register, which raises
// m_tvalid, once that register is empty or being read. One word per cycle is
// sustained while m_tready stays high; a stall holds the word in the input register.
// Configuration words on the cfg_ channel are always accepted and take effect once
// registered; write them only while no word is in flight.
// Reset (aresetn low, synchronous) returns to Slave mode with the timer disarmed,
// empties both registers and restores the default timeouts and hours.
// When the receiver stalls, the result is held in the output register and one
// further word is taken into the input register; s_tready then drops until
// m_tready rises.
module intrusion_alarm_mode_controller #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // target_mode[2:0], hour_now[7:3], motion_total[11:8], motion_bed[15:12],
    // motion_outer[19:16], zero[23:20]
    input  logic [iamc_pkg::S_TDATA_W-1:0]       s_tdata,
    // opcode[1:0]
    input  logic [iamc_pkg::S_TUSER_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // mode_now[2:0], mode_before[5:3], mode_entered[6], timer_running[7],
    // wall_warning[8], zero[15:9]
    output logic [iamc_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [iamc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [iamc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    iamc_pkg::cfg_t           cfg;
    logic                     in_valid_reg;
    logic                     in_valid_next;
    iamc_pkg::item_t          in_item_reg;
    logic [1:0]               in_op_reg;
    iamc_pkg::mode_t          mode_reg;
    iamc_pkg::mode_t          mode_next;
    logic [TIMER_WIDTH-1:0]   count_reg;
    logic [TIMER_WIDTH-1:0]   count_next;
    logic                     armed_reg;
    logic                     armed_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    iamc_pkg::result_t        out_res_reg;
    iamc_pkg::result_t        step_res;
    logic                     advance;
    logic                     s_accept;

    assign cfg_ready = 1'b1;

    iamc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    iamc_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .cfg        (cfg),
        .opcode     (in_op_reg),
        .item       (in_item_reg),
        .mode       (mode_reg),
        .count      (count_reg),
        .armed      (armed_reg),
        .mode_next  (mode_next),
        .count_next (count_next),
        .armed_next (armed_next),
        .result     (step_res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= iamc_pkg::MODE_SLAVE;
            count_reg     <= '0;
            armed_reg     <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
                armed_reg <= armed_next;
            end
        end
    end

    // payload: hold unless a word moves in
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_tdata[$bits(iamc_pkg::item_t)-1:0];
            in_op_reg   <= s_tuser;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(iamc_pkg::M_TDATA_W - $bits(iamc_pkg::result_t)){1'b0}}, out_res_reg};

`ifndef NO_ASSERTIONS
    a_armed_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        armed_reg |-> count_reg != '0)
        else $error("timer armed with zero countdown");

    a_mode_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_res_reg.mode_now == mode_reg)
        else $error("result mode differs from stored mode");

    a_armed_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_res_reg.timer_running == armed_reg)
        else $error("result timer flag differs from stored armed bit");
`endif

endmodule
